[hw/rtl/utf8_text_cursor_layout_top_assert.svh]
// ----------------------------------------------------------------------------
// utf8 text cursor layout - assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef UTF8_TEXT_CURSOR_LAYOUT_TOP_ASSERT_SVH
`define UTF8_TEXT_CURSOR_LAYOUT_TOP_ASSERT_SVH

// same-cycle implication, off while in reset
`define UTCL_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("utcl assertion failed");

// next-cycle implication, off while in reset
`define UTCL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("utcl assertion failed");

`endif

[hw/rtl/utcl_pkg.sv]
// ----------------------------------------------------------------------------
// utcl_pkg
// shared types, constants and code mapping for the text cursor layout block
// ----------------------------------------------------------------------------
`default_nettype none

package utcl_pkg;

	// field widths
	localparam int BYTE_W    = 8;
	localparam int ADV_W     = 7;
	localparam int POS_W     = 10;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 10;
	localparam int CP_W      = 11;

	// parameter defaults
	localparam int GLYPH_TABLE_DEPTH_DEF = 256;
	localparam int CURSOR_BITS_DEF       = 10;

	typedef enum logic [1:0] {
		ACT_TEXT = 2'd0,
		ACT_LOAD = 2'd1,
		ACT_SET  = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef enum logic {
		OP_GLYPH = 1'b0,
		OP_SET   = 1'b1
	} op_t;

	typedef enum logic {
		CMD_DRAW  = 1'b0,
		CMD_CLEAR = 1'b1
	} cmd_kind_t;

	typedef enum logic [2:0] {
		CFG_FIRST_CODE    = 3'd0,
		CFG_LAST_CODE     = 3'd1,
		CFG_LINE_HEIGHT   = 3'd2,
		CFG_LETTER_SPACE  = 3'd3,
		CFG_LINE_SPACE    = 3'd4,
		CFG_SCREEN_WIDTH  = 3'd5,
		CFG_SCREEN_HEIGHT = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0]        first_code;
		logic [7:0]        last_code;
		logic [7:0]        line_height;
		logic signed [3:0] char_gap;
		logic [4:0]        row_gap;
		logic [9:0]        screen_width;
		logic [9:0]        screen_height;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		first_code:     8'd32,
		last_code:      8'd255,
		line_height:    8'd16,
		char_gap:       -4'sd3,
		row_gap:        5'd8,
		screen_width:   10'd160,
		screen_height:  10'd128
	};

	// byte classes
	localparam logic [7:0] BYTE_ASCII_LIM = 8'h80;
	localparam logic [7:0] BYTE_NEWLINE   = 8'h0A;
	localparam logic [2:0] BYTE_LEAD_TAG  = 3'b110;
	localparam logic [2:0] BYTE_SOLO_TAG  = 3'b111;
	localparam logic [7:0] FC_SPACE       = 8'h20;

	// code points
	localparam logic [CP_W-1:0] CP_ASCII_LIM = 11'h080;
	localparam logic [CP_W-1:0] CP_SOLO_BASE = 11'h410;
	localparam logic [CP_W-1:0] CP_UP_LO     = 11'h410;
	localparam logic [CP_W-1:0] CP_UP_HI     = 11'h42F;
	localparam logic [CP_W-1:0] CP_LOA_LO    = 11'h430;
	localparam logic [CP_W-1:0] CP_LOA_HI    = 11'h43F;
	localparam logic [CP_W-1:0] CP_LOB_LO    = 11'h440;
	localparam logic [CP_W-1:0] CP_LOB_HI    = 11'h44F;
	localparam logic [CP_W-1:0] CP_UKR_I_UP  = 11'h406;
	localparam logic [CP_W-1:0] CP_UKR_I_LO  = 11'h456;
	localparam logic [CP_W-1:0] CP_UKR_YI_UP = 11'h407;
	localparam logic [CP_W-1:0] CP_UKR_YI_LO = 11'h457;
	localparam logic [CP_W-1:0] CP_UKR_YE_UP = 11'h404;
	localparam logic [CP_W-1:0] CP_UKR_YE_LO = 11'h454;
	localparam logic [CP_W-1:0] CP_UKR_GE_UP = 11'h490;
	localparam logic [CP_W-1:0] CP_UKR_GE_LO = 11'h491;

	// font codes
	localparam logic [7:0] FC_UP       = 8'h90;
	localparam logic [7:0] FC_LOA      = 8'hB0;
	localparam logic [7:0] FC_LOB      = 8'h80;
	localparam logic [7:0] FC_I_UP     = 8'hC4;
	localparam logic [7:0] FC_I_LO     = 8'hC5;
	localparam logic [7:0] FC_YI_UP    = 8'hC6;
	localparam logic [7:0] FC_YI_LO    = 8'hC7;
	localparam logic [7:0] FC_YE_UP    = 8'hC2;
	localparam logic [7:0] FC_YE_LO    = 8'hC3;
	localparam logic [7:0] FC_GE_UP    = 8'hC8;
	localparam logic [7:0] FC_GE_LO    = 8'hC9;

	// decoded glyph or set-cursor on its way to the layout stage
	typedef struct packed {
		op_t              op;
		logic [7:0]       glyph;
		logic             newline;
		logic             in_table;
		logic [POS_W-1:0] set_x;
		logic [POS_W-1:0] set_y;
	} stage_t;

	// up to two commands from one text byte
	typedef struct packed {
		logic             has_clear;
		logic             has_draw;
		logic [7:0]       glyph;
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
	} run_t;

	function automatic logic [7:0] map_code(input logic [CP_W-1:0] u);
		if (u < CP_ASCII_LIM) begin
			return u[7:0];
		end else if (u >= CP_UP_LO && u <= CP_UP_HI) begin
			return FC_UP + 8'(u - CP_UP_LO);
		end else if (u >= CP_LOA_LO && u <= CP_LOA_HI) begin
			return FC_LOA + 8'(u - CP_LOA_LO);
		end else if (u >= CP_LOB_LO && u <= CP_LOB_HI) begin
			return FC_LOB + 8'(u - CP_LOB_LO);
		end else if (u == CP_UKR_I_UP) begin
			return FC_I_UP;
		end else if (u == CP_UKR_I_LO) begin
			return FC_I_LO;
		end else if (u == CP_UKR_YI_UP) begin
			return FC_YI_UP;
		end else if (u == CP_UKR_YI_LO) begin
			return FC_YI_LO;
		end else if (u == CP_UKR_YE_UP) begin
			return FC_YE_UP;
		end else if (u == CP_UKR_YE_LO) begin
			return FC_YE_LO;
		end else if (u == CP_UKR_GE_UP) begin
			return FC_GE_UP;
		end else if (u == CP_UKR_GE_LO) begin
			return FC_GE_LO;
		end else begin
			return FC_SPACE;
		end
	endfunction

endpackage

`default_nettype wire

[hw/rtl/utcl_if.sv]
// ----------------------------------------------------------------------------
// utcl channel interfaces
// valid/ready channels for text items and layout commands
// ----------------------------------------------------------------------------
`default_nettype none

interface utcl_text_if import utcl_pkg::*; ;
	logic              valid;
	logic              ready;
	logic [1:0]        action;
	logic [BYTE_W-1:0] byte_value;
	logic [ADV_W-1:0]  advance_width;
	logic [POS_W-1:0]  set_cursor_x;
	logic [POS_W-1:0]  set_cursor_y;

	modport source (
		output valid, action, byte_value, advance_width, set_cursor_x, set_cursor_y,
		input  ready
	);
	modport sink (
		input  valid, action, byte_value, advance_width, set_cursor_x, set_cursor_y,
		output ready
	);
endinterface

interface utcl_cmd_if import utcl_pkg::*; ;
	logic             valid;
	logic             ready;
	logic             command_kind;
	logic [7:0]       glyph_code;
	logic [POS_W-1:0] pos_x;
	logic [POS_W-1:0] pos_y;
	logic             last_of_run;

	modport source (
		output valid, command_kind, glyph_code, pos_x, pos_y, last_of_run,
		input  ready
	);
	modport sink (
		input  valid, command_kind, glyph_code, pos_x, pos_y, last_of_run,
		output ready
	);
endinterface

`default_nettype wire

[hw/rtl/utcl_decode.sv]
// ----------------------------------------------------------------------------
// utcl_decode
// utf-8 decode, font code mapping, advance table and the stage 1 register
// ----------------------------------------------------------------------------
`default_nettype none

module utcl_decode import utcl_pkg::*; #(
	parameter int GLYPH_TABLE_DEPTH = GLYPH_TABLE_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [1:0]        action,
	input  wire logic [BYTE_W-1:0] byte_value,
	input  wire logic [ADV_W-1:0]  advance_width,
	input  wire logic [POS_W-1:0]  set_cursor_x,
	input  wire logic [POS_W-1:0]  set_cursor_y,
	input  wire cfg_t              cfg,
	output logic                   valid_s1,
	output stage_t                 item_s1,
	output logic [ADV_W-1:0]       width_s1,
	input  wire logic              take_s1
);

	localparam int AW = $clog2(GLYPH_TABLE_DEPTH);

	logic [ADV_W-1:0] adv_mem [GLYPH_TABLE_DEPTH];

	logic            lead_pending_q;
	logic [4:0]      lead_bits_q;
	logic            accept;
	logic            is_text;
	logic            emit;
	logic            is_lead;
	logic            newline;
	logic [CP_W-1:0] cp;
	logic [7:0]      mapped;
	logic [7:0]      glyph;
	logic            glyph_in_table;
	logic            load_in_table;
	logic            enter;
	stage_t          item_d;

	assign in_ready = !valid_s1 || take_s1;
	assign accept   = in_valid && in_ready;
	assign is_text  = (action == ACT_TEXT);

	always_comb begin
		emit    = 1'b0;
		is_lead = 1'b0;
		newline = 1'b0;
		cp      = '0;
		if (lead_pending_q) begin
			// any byte after a lead completes the pair
			emit = 1'b1;
			cp   = {lead_bits_q, byte_value[5:0]};
		end else if (byte_value < BYTE_ASCII_LIM) begin
			emit    = 1'b1;
			cp      = CP_W'(byte_value);
			newline = (byte_value == BYTE_NEWLINE);
		end else if (byte_value[7:5] == BYTE_LEAD_TAG) begin
			is_lead = 1'b1;
		end else if (byte_value[7:5] == BYTE_SOLO_TAG) begin
			emit = 1'b1;
			cp   = CP_SOLO_BASE + CP_W'(byte_value[5:0]);
		end
	end

	assign mapped = map_code(cp);
	assign glyph  = (mapped < cfg.first_code || mapped > cfg.last_code) ? FC_SPACE : mapped;
	assign glyph_in_table = ({1'b0, glyph} < 9'(GLYPH_TABLE_DEPTH));
	assign load_in_table  = ({1'b0, byte_value} < 9'(GLYPH_TABLE_DEPTH));
	assign enter = (is_text && emit) || (action == ACT_SET);

	always_comb begin
		item_d          = '0;
		item_d.op       = (action == ACT_SET) ? OP_SET : OP_GLYPH;
		item_d.glyph    = glyph;
		item_d.newline  = newline;
		item_d.in_table = glyph_in_table;
		item_d.set_x    = set_cursor_x;
		item_d.set_y    = set_cursor_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_pending_q <= 1'b0;
			lead_bits_q    <= '0;
		end else if (accept && is_text) begin
			if (lead_pending_q) begin
				lead_pending_q <= 1'b0;
			end else if (is_lead) begin
				lead_pending_q <= 1'b1;
				lead_bits_q    <= byte_value[4:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= accept && enter;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_d;
		end
	end

	// advance table, one write port and one registered read port
	always_ff @(posedge clk) begin
		if (accept && action == ACT_LOAD && load_in_table) begin
			adv_mem[byte_value[AW-1:0]] <= advance_width;
		end
		if (accept && is_text && emit && glyph_in_table) begin
			width_s1 <= adv_mem[glyph[AW-1:0]];
		end
	end

endmodule

`default_nettype wire

[hw/rtl/utcl_layout.sv]
// ----------------------------------------------------------------------------
// utcl_layout
// cursor state, advance, line wrap and screen overflow
// ----------------------------------------------------------------------------
`default_nettype none

module utcl_layout import utcl_pkg::*; #(
	parameter int CURSOR_BITS = CURSOR_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cfg_t             cfg,
	input  wire logic             valid_s1,
	input  wire stage_t           item_s1,
	input  wire logic [ADV_W-1:0] width_s1,
	output logic                  take_s1,
	input  wire logic             room,
	output logic                  push,
	output run_t                  run
);

	// wide enough for every sum before wrapping
	localparam int WIDE = ((CURSOR_BITS > POS_W) ? CURSOR_BITS : POS_W) + 2;

	logic [CURSOR_BITS-1:0] col_q;
	logic [CURSOR_BITS-1:0] row_q;

	logic [ADV_W-1:0]       width;
	logic signed [8:0]      adv_raw;
	logic [7:0]             adv;
	logic [WIDE-1:0]        col_sum;
	logic                   wrap;
	logic [WIDE-1:0]        row_a;
	logic [WIDE-1:0]        row_bot;
	logic                   clear;
	logic [CURSOR_BITS-1:0] row_n;
	logic [CURSOR_BITS-1:0] col_draw;
	logic [CURSOR_BITS-1:0] col_n;
	logic                   draw;
	logic [WIDE-1:0]        col_wide;
	logic [WIDE-1:0]        row_wide;
	logic [WIDE-1:0]        col_next_wide;
	logic [WIDE-1:0]        set_x_wide;
	logic [WIDE-1:0]        set_y_wide;

	assign take_s1 = valid_s1 && room;

	assign width   = item_s1.in_table ? width_s1 : '0;
	assign adv_raw = $signed({2'b00, width}) + 9'(cfg.char_gap);
	assign adv     = (adv_raw < 9'sd1) ? 8'd1 : adv_raw[7:0];

	assign col_sum = WIDE'(col_q) + WIDE'(adv);
	assign wrap    = (col_sum > WIDE'(cfg.screen_width)) || item_s1.newline;
	assign row_a   = wrap ? (WIDE'(row_q) + WIDE'(cfg.line_height) + WIDE'(cfg.row_gap))
	                      : WIDE'(row_q);
	assign row_bot = row_a + WIDE'(cfg.line_height);
	assign clear   = (row_bot > WIDE'(cfg.screen_height));
	assign row_n   = clear ? '0 : row_a[CURSOR_BITS-1:0];

	assign col_draw      = wrap ? '0 : col_q;
	assign draw          = !item_s1.newline;
	assign col_next_wide = WIDE'(col_draw) + WIDE'(adv);
	assign col_n         = draw ? col_next_wide[CURSOR_BITS-1:0] : col_draw;

	assign col_wide   = WIDE'(col_draw);
	assign row_wide   = WIDE'(row_n);
	assign set_x_wide = WIDE'(item_s1.set_x);
	assign set_y_wide = WIDE'(item_s1.set_y);

	always_comb begin
		run.has_clear = clear;
		run.has_draw  = draw;
		run.glyph     = item_s1.glyph;
		run.pos_x     = col_wide[POS_W-1:0];
		run.pos_y     = row_wide[POS_W-1:0];
	end

	assign push = take_s1 && (item_s1.op == OP_GLYPH) && (clear || draw);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (take_s1) begin
			case (item_s1.op)
				OP_SET: begin
					col_q <= set_x_wide[CURSOR_BITS-1:0];
					row_q <= set_y_wide[CURSOR_BITS-1:0];
				end
				OP_GLYPH: begin
					col_q <= col_n;
					row_q <= row_n;
				end
				default: begin
					col_q <= col_q;
					row_q <= row_q;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[hw/rtl/utcl_outq.sv]
// ----------------------------------------------------------------------------
// utcl_outq
// two-entry command queue that plays each run out as clear, then draw
// ----------------------------------------------------------------------------
`default_nettype none

module utcl_outq import utcl_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire run_t  run,
	output logic       room,
	output logic       out_valid,
	input  wire logic  out_ready,
	output cmd_kind_t  command_kind,
	output logic [7:0] glyph_code,
	output logic [POS_W-1:0] pos_x,
	output logic [POS_W-1:0] pos_y,
	output logic       last_of_run
);

	run_t       entry_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;
	logic       phase_q;

	run_t       head;
	logic       show_clear;
	logic       fire;
	logic       pop;

	assign room       = (count_q != 2'd2);
	assign out_valid  = (count_q != 2'd0);
	assign head       = entry_q[rd_q];
	assign show_clear = head.has_clear && !phase_q;

	always_comb begin
		if (show_clear) begin
			command_kind = CMD_CLEAR;
			glyph_code   = '0;
			pos_x        = '0;
			pos_y        = '0;
			last_of_run  = !head.has_draw;
		end else begin
			command_kind = CMD_DRAW;
			glyph_code   = head.glyph;
			pos_x        = head.pos_x;
			pos_y        = head.pos_y;
			last_of_run  = 1'b1;
		end
	end

	assign fire = out_valid && out_ready;
	assign pop  = fire && last_of_run;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= run;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= '0;
			phase_q <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
			// second half of a clear+draw run
			if (fire) begin
				phase_q <= !last_of_run;
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/utf8_text_cursor_layout_top.sv]
// ----------------------------------------------------------------------------
// utf8_text_cursor_layout_top
// utf-8 text bytes in, glyph draw and clear screen commands out
// ----------------------------------------------------------------------------
//  channel   dir   carries
//  text_in   in    action, byte_value, advance_width, set_cursor_x/y
//  cmd_out   out   command_kind, glyph_code, pos_x, pos_y, last_of_run
//  cfg_*     in    write-only register port, index 0..6
//
//  one input transaction per cycle while the queue has room; a text byte passes
//  through stage 1 (table read) and then the cursor update into the queue to cmd_out
//  a byte that causes a clear and a draw holds the command port for both, clear first
//  the cursor loop (column add, wrap compare, row add, overflow compare)
//  is combinational and closes on the cursor registers in the layout stage
//  arst_n clears the cursor, the pending lead and the queue; the advance
//  table is not cleared and must be loaded before use
//  a stall on cmd_out fills the two-entry queue and then drops text_in.ready
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_text_cursor_layout_top import utcl_pkg::*; #(
	parameter int GLYPH_TABLE_DEPTH = GLYPH_TABLE_DEPTH_DEF,
	parameter int CURSOR_BITS       = CURSOR_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	utcl_text_if.sink                 text_in,
	utcl_cmd_if.source                cmd_out,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_data
);

	cfg_t             cfg_q;
	logic             in_ready;
	logic             valid_s1;
	stage_t           item_s1;
	logic [ADV_W-1:0] width_s1;
	logic             take_s1;
	logic             room;
	logic             push;
	run_t             run;
	cmd_kind_t        kind;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FIRST_CODE:    cfg_q.first_code    <= cfg_data[7:0];
				CFG_LAST_CODE:     cfg_q.last_code     <= cfg_data[7:0];
				CFG_LINE_HEIGHT:   cfg_q.line_height   <= cfg_data[7:0];
				CFG_LETTER_SPACE:  cfg_q.char_gap      <= $signed(cfg_data[3:0]);
				CFG_LINE_SPACE:    cfg_q.row_gap       <= cfg_data[4:0];
				CFG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data;
				CFG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data;
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	utcl_decode #(
		.GLYPH_TABLE_DEPTH(GLYPH_TABLE_DEPTH)
	) u_decode (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (text_in.valid),
		.in_ready      (in_ready),
		.action        (text_in.action),
		.byte_value    (text_in.byte_value),
		.advance_width (text_in.advance_width),
		.set_cursor_x  (text_in.set_cursor_x),
		.set_cursor_y  (text_in.set_cursor_y),
		.cfg           (cfg_q),
		.valid_s1      (valid_s1),
		.item_s1       (item_s1),
		.width_s1      (width_s1),
		.take_s1       (take_s1)
	);

	assign text_in.ready = in_ready;

	utcl_layout #(
		.CURSOR_BITS(CURSOR_BITS)
	) u_layout (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.width_s1 (width_s1),
		.take_s1  (take_s1),
		.room     (room),
		.push     (push),
		.run      (run)
	);

	utcl_outq u_outq (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.run          (run),
		.room         (room),
		.out_valid    (cmd_out.valid),
		.out_ready    (cmd_out.ready),
		.command_kind (kind),
		.glyph_code   (cmd_out.glyph_code),
		.pos_x        (cmd_out.pos_x),
		.pos_y        (cmd_out.pos_y),
		.last_of_run  (cmd_out.last_of_run)
	);

	assign cmd_out.command_kind = kind;

endmodule

`default_nettype wire

[hw/rtl/utcl_checker.sv]
// ----------------------------------------------------------------------------
// utcl_checker
// port-level checks on the command stream of the layout block
// ----------------------------------------------------------------------------
`default_nettype none

`include "utf8_text_cursor_layout_top_assert.svh"

module utcl_checker import utcl_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             cmd_valid,
	input wire logic             cmd_ready,
	input wire logic             command_kind,
	input wire logic [7:0]       glyph_code,
	input wire logic [POS_W-1:0] pos_x,
	input wire logic [POS_W-1:0] pos_y,
	input wire logic             last_of_run
);

	logic                 cmd_fire;
	logic                 clear_then_draw;
	logic                 is_clear;
	logic                 is_draw;
	logic                 clear_zero;
	logic                 draw_top;
	logic                 cmd_wait;
	logic [2*POS_W+9:0]   cmd_word;

	assign cmd_fire        = cmd_valid && cmd_ready;
	assign clear_then_draw = cmd_fire && (command_kind == CMD_CLEAR) && !last_of_run;
	assign is_clear        = cmd_valid && (command_kind == CMD_CLEAR);
	assign is_draw         = cmd_valid && (command_kind == CMD_DRAW);
	assign clear_zero      = (glyph_code == 8'd0) && (pos_x == '0) && (pos_y == '0);
	assign draw_top        = is_draw && (pos_y == '0);
	assign cmd_wait        = cmd_valid && !cmd_ready;
	assign cmd_word        = {command_kind, glyph_code, pos_x, pos_y, last_of_run};

	// a clear carries no glyph and no position
	`UTCL_ASSERT_IMPLY(a_clear_zero, clk, arst_n, is_clear, clear_zero)

	// a draw always ends its run
	`UTCL_ASSERT_IMPLY(a_draw_last, clk, arst_n, is_draw, last_of_run)

	// the draw after a clear follows at once, on the top row
	`UTCL_ASSERT_NEXT(a_clear_draw, clk, arst_n, clear_then_draw, draw_top)

	// a stalled command holds
	`UTCL_ASSERT_NEXT(a_hold, clk, arst_n, cmd_wait, cmd_valid && $stable(cmd_word))

endmodule

bind utf8_text_cursor_layout_top utcl_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cmd_valid    (cmd_out.valid),
	.cmd_ready    (cmd_out.ready),
	.command_kind (cmd_out.command_kind),
	.glyph_code   (cmd_out.glyph_code),
	.pos_x        (cmd_out.pos_x),
	.pos_y        (cmd_out.pos_y),
	.last_of_run  (cmd_out.last_of_run)
);

`default_nettype wire

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// testbench for the utf-8 text cursor layout block: drives text, table load
// and set-cursor transactions, predicts the draw and clear commands, and
// checks every command in order under several register settings and idling
// ----------------------------------------------------------------------------

module tb_top;
	import utcl_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 70;
	localparam int SETTLE_CYCLES = 8;

	typedef struct packed {
		action_t          action;
		logic [7:0]       byte_value;
		logic [ADV_W-1:0] advance_width;
		logic [POS_W-1:0] set_x;
		logic [POS_W-1:0] set_y;
	} text_item_t;

	typedef struct packed {
		cmd_kind_t        kind;
		logic [7:0]       glyph;
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
		logic             last;
	} layout_cmd_t;

	class cursor_layout_tracker;
		logic [7:0]        first_code;
		logic [7:0]        last_code;
		logic [7:0]        line_height;
		logic signed [3:0] char_gap;
		logic [4:0]        row_gap;
		logic [9:0]        screen_width;
		logic [9:0]        screen_height;

		logic [POS_W-1:0] col;
		logic [POS_W-1:0] row;
		bit               lead_pending;
		logic [4:0]       lead_bits;
		logic [ADV_W-1:0] adv_table [256];

		layout_cmd_t due_cmds [$];
		int          errors;

		function new();
			first_code     = CFG_RESET.first_code;
			last_code      = CFG_RESET.last_code;
			line_height    = CFG_RESET.line_height;
			char_gap       = CFG_RESET.char_gap;
			row_gap        = CFG_RESET.row_gap;
			screen_width   = CFG_RESET.screen_width;
			screen_height  = CFG_RESET.screen_height;
			col            = '0;
			row            = '0;
			lead_pending   = 0;
			lead_bits      = '0;
			errors         = 0;
			foreach (adv_table[i])
				adv_table[i] = '0;
		endfunction

		function void set_register(cfg_idx_t idx, logic [CFG_DAT_W-1:0] d);
			case (idx)
				CFG_FIRST_CODE:    first_code     = d[7:0];
				CFG_LAST_CODE:     last_code      = d[7:0];
				CFG_LINE_HEIGHT:   line_height    = d[7:0];
				CFG_LETTER_SPACE:  char_gap       = d[3:0];
				CFG_LINE_SPACE:    row_gap        = d[4:0];
				CFG_SCREEN_WIDTH:  screen_width   = d[9:0];
				CFG_SCREEN_HEIGHT: screen_height  = d[9:0];
				default: ;
			endcase
		endfunction

		function logic [7:0] font_code(logic [CP_W-1:0] cp);
			if (cp < CP_ASCII_LIM)
				return cp[7:0];
			if (cp >= CP_UP_LO && cp <= CP_UP_HI)
				return FC_UP + 8'(cp - CP_UP_LO);
			if (cp >= CP_LOA_LO && cp <= CP_LOA_HI)
				return FC_LOA + 8'(cp - CP_LOA_LO);
			if (cp >= CP_LOB_LO && cp <= CP_LOB_HI)
				return FC_LOB + 8'(cp - CP_LOB_LO);
			case (cp)
				CP_UKR_YE_UP: return FC_YE_UP;
				CP_UKR_YE_LO: return FC_YE_LO;
				CP_UKR_I_UP:  return FC_I_UP;
				CP_UKR_I_LO:  return FC_I_LO;
				CP_UKR_YI_UP: return FC_YI_UP;
				CP_UKR_YI_LO: return FC_YI_LO;
				CP_UKR_GE_UP: return FC_GE_UP;
				CP_UKR_GE_LO: return FC_GE_LO;
				default:      return FC_SPACE;
			endcase
		endfunction

		// decode one accepted transaction and queue the commands it causes
		function void accept_item(text_item_t it);
			logic [CP_W-1:0] cp;
			logic [7:0]      code;
			int              adv;
			int              next_row;
			bit              newline;
			layout_cmd_t     run [$];
			layout_cmd_t     c;

			newline = 0;
			case (it.action)
				ACT_LOAD: begin
					adv_table[it.byte_value] = it.advance_width;
					return;
				end
				ACT_SET: begin
					col = it.set_x;
					row = it.set_y;
					return;
				end
				ACT_TEXT: ;
				default: return;
			endcase

			if (lead_pending) begin
				cp = {lead_bits, it.byte_value[5:0]};
				lead_pending = 0;
			end else if (it.byte_value < BYTE_ASCII_LIM) begin
				cp = CP_W'(it.byte_value);
				newline = (it.byte_value == BYTE_NEWLINE);
			end else if (it.byte_value[7:5] == BYTE_LEAD_TAG) begin
				lead_pending = 1;
				lead_bits = it.byte_value[4:0];
				return;
			end else if (it.byte_value[7:5] == BYTE_SOLO_TAG) begin
				cp = CP_SOLO_BASE + CP_W'(it.byte_value[5:0]);
			end else begin
				return;
			end

			code = font_code(cp);
			if (code < first_code || code > last_code)
				code = FC_SPACE;
			adv = int'(adv_table[code]) + int'(char_gap);
			if (adv < 1)
				adv = 1;

			next_row = int'(row);
			if (int'(col) + adv > int'(screen_width) || newline) begin
				col = '0;
				next_row = int'(row) + int'(line_height) + int'(row_gap);
			end
			if (next_row + int'(line_height) > int'(screen_height)) begin
				next_row = 0;
				c = '{kind: CMD_CLEAR, glyph: '0, pos_x: '0, pos_y: '0, last: 1'b0};
				run.push_back(c);
			end
			row = POS_W'(next_row);

			if (!newline) begin
				c = '{kind: CMD_DRAW, glyph: code, pos_x: col, pos_y: row, last: 1'b0};
				run.push_back(c);
				col = POS_W'(int'(col) + adv);
			end
			if (run.size() > 0)
				run[run.size() - 1].last = 1'b1;
			foreach (run[i])
				due_cmds.push_back(run[i]);
		endfunction

		function void check_cmd(layout_cmd_t got);
			layout_cmd_t want;

			if (due_cmds.size() == 0) begin
				$display("%0t unexpected command: kind %0d glyph %h x %0d y %0d last %0d",
					$time, got.kind, got.glyph, got.pos_x, got.pos_y, got.last);
				errors++;
				return;
			end
			want = due_cmds.pop_front();
			if (got.kind !== want.kind) begin
				$display("%0t command_kind: expected %0d actual %0d", $time, want.kind, got.kind);
				errors++;
			end
			if (got.glyph !== want.glyph) begin
				$display("%0t glyph_code: expected %h actual %h", $time, want.glyph, got.glyph);
				errors++;
			end
			if (got.pos_x !== want.pos_x) begin
				$display("%0t pos_x: expected %0d actual %0d", $time, want.pos_x, got.pos_x);
				errors++;
			end
			if (got.pos_y !== want.pos_y) begin
				$display("%0t pos_y: expected %0d actual %0d", $time, want.pos_y, got.pos_y);
				errors++;
			end
			if (got.last !== want.last) begin
				$display("%0t last_of_run: expected %0d actual %0d", $time, want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	utcl_text_if text_bus ();
	utcl_cmd_if  cmd_bus ();

	utf8_text_cursor_layout_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.text_in   (text_bus),
		.cmd_out   (cmd_bus),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	cursor_layout_tracker tracker;
	int          idle_send_pct = 0;
	int          stall_pct     = 0;
	int          text_sent     = 0;
	int unsigned cycle_count   = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(negedge clk) begin
		cmd_bus.ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		text_item_t  ti;
		layout_cmd_t cm;

		if (arst_n && text_bus.valid && text_bus.ready) begin
			ti.action        = action_t'(text_bus.action);
			ti.byte_value    = text_bus.byte_value;
			ti.advance_width = text_bus.advance_width;
			ti.set_x         = text_bus.set_cursor_x;
			ti.set_y         = text_bus.set_cursor_y;
			tracker.accept_item(ti);
		end
		if (arst_n && cmd_bus.valid && cmd_bus.ready) begin
			cm.kind  = cmd_kind_t'(cmd_bus.command_kind);
			cm.glyph = cmd_bus.glyph_code;
			cm.pos_x = cmd_bus.pos_x;
			cm.pos_y = cmd_bus.pos_y;
			cm.last  = cmd_bus.last_of_run;
			tracker.check_cmd(cm);
		end
	end

	function automatic text_item_t make_item(action_t a, logic [7:0] b);
		text_item_t it;

		it.action        = a;
		it.byte_value    = b;
		it.advance_width = ADV_W'($urandom_range(127, 0));
		it.set_x         = POS_W'($urandom_range(1023, 0));
		it.set_y         = POS_W'($urandom_range(1023, 0));
		return it;
	endfunction

	function automatic int pick(int lo, int hi);
		int r;

		r = $urandom_range(2, 0);
		if (r == 0)
			return lo;
		if (r == 1)
			return hi;
		return $urandom_range(hi, lo);
	endfunction

	task automatic set_idle(int mode);
		case (mode)
			0: begin idle_send_pct = 0;  stall_pct = 0;  end
			1: begin idle_send_pct = 45; stall_pct = 0;  end
			2: begin idle_send_pct = 0;  stall_pct = 45; end
			default: begin idle_send_pct = 29; stall_pct = 29; end
		endcase
	endtask

	task automatic send_item(text_item_t it);
		@(negedge clk);
		while ($urandom_range(99) < idle_send_pct) begin
			text_bus.valid <= 1'b0;
			@(negedge clk);
		end
		text_bus.valid         <= 1'b1;
		text_bus.action        <= it.action;
		text_bus.byte_value    <= it.byte_value;
		text_bus.advance_width <= it.advance_width;
		text_bus.set_cursor_x  <= it.set_x;
		text_bus.set_cursor_y  <= it.set_y;
		@(posedge clk);
		while (!text_bus.ready)
			@(posedge clk);
		if (it.action == ACT_TEXT)
			text_sent++;
	endtask

	task automatic send_text(logic [7:0] b);
		send_item(make_item(ACT_TEXT, b));
	endtask

	task automatic stop_sending();
		@(negedge clk);
		text_bus.valid <= 1'b0;
	endtask

	// pipeline may still hold items that cause nothing, so let it settle after the last due command
	task automatic drain_block();
		while (tracker.due_cmds.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_DAT_W-1:0] d);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(negedge clk);
		cfg_we    <= 1'b0;
		tracker.set_register(idx, d);
	endtask

	task automatic program_phase(int phase);
		logic [CFG_DAT_W-1:0] v [7];
		int                   ls;

		case (phase)
			1: v = '{10'd0, 10'd255, 10'd0, 10'h008, 10'd0, 10'd1023, 10'd1023};
			2: v = '{10'd32, 10'd0, 10'd255, 10'h007, 10'd31, 10'd1, 10'd1};
			default: begin
				if ($urandom_range(1, 0) == 0) begin
					v[0] = CFG_DAT_W'($urandom_range(32, 0));
					v[1] = CFG_DAT_W'($urandom_range(255, 200));
					v[2] = CFG_DAT_W'($urandom_range(24, 8));
					ls   = int'($urandom_range(6, 0)) - 4;
					v[4] = CFG_DAT_W'($urandom_range(8, 0));
					v[5] = CFG_DAT_W'($urandom_range(400, 40));
					v[6] = CFG_DAT_W'($urandom_range(300, 40));
				end else begin
					v[0] = CFG_DAT_W'(pick(0, 255));
					v[1] = CFG_DAT_W'(pick(0, 255));
					v[2] = CFG_DAT_W'(pick(0, 255));
					ls   = pick(0, 15) - 8;
					v[4] = CFG_DAT_W'(pick(0, 31));
					v[5] = CFG_DAT_W'(pick(1, 1023));
					v[6] = CFG_DAT_W'(pick(1, 1023));
				end
				v[3] = CFG_DAT_W'(ls & 15);
			end
		endcase
		for (int i = 0; i < 7; i++)
			write_reg(cfg_idx_t'(i), v[i]);
	endtask

	task automatic run_directed();
		text_item_t it;

		send_text(8'h41);
		send_text(8'h00);
		send_text(8'h7F);
		send_text(BYTE_NEWLINE);
		// cyrillic upper, lower in both ranges, ukrainian letters
		send_text(8'hD0); send_text(8'h90);
		send_text(8'hD1); send_text(8'h8F);
		send_text(8'hD0); send_text(8'hB0);
		send_text(8'hD0); send_text(8'h86);
		send_text(8'hD2); send_text(8'h91);
		// single-byte forms at both ends
		send_text(8'hE0);
		send_text(8'hFF);
		// lone continuation is dropped
		send_text(8'h85);
		// lead after lead, then overlong pair decoding to a newline code
		send_text(8'hC3); send_text(8'hC5);
		send_text(8'hC0); send_text(8'h8A);
		send_item(make_item(ACT_NONE, 8'h41));
		// cursor at the far corner forces wrap and clear
		it = make_item(ACT_SET, 8'h00);
		it.set_x = '1;
		it.set_y = '1;
		send_item(it);
		send_text(8'h42);
		// table load while a lead waits
		send_text(8'hD0);
		it = make_item(ACT_LOAD, FC_UP);
		it.advance_width = ADV_W'($urandom_range(12, 1));
		send_item(it);
		send_text(8'h90);
	endtask

	task automatic send_random_unit();
		int         r;
		text_item_t it;

		r = $urandom_range(99, 0);
		if (r < 35) begin
			send_text(8'($urandom_range(8'h7E, 8'h20)));
		end else if (r < 43) begin
			send_text(BYTE_NEWLINE);
		end else if (r < 68) begin
			send_text(8'($urandom_range(8'hD2, 8'hD0)));
			send_text(8'($urandom_range(8'hBF, 8'h80)));
		end else if (r < 75) begin
			send_text(8'($urandom_range(8'hDF, 8'hC0)));
			send_text(8'($urandom_range(8'hBF, 8'h80)));
		end else if (r < 81) begin
			send_text(8'($urandom_range(8'hFF, 8'hE0)));
		end else if (r < 85) begin
			send_text(8'($urandom_range(255, 0)));
		end else if (r < 88) begin
			send_text(8'($urandom_range(8'hBF, 8'h80)));
		end else if (r < 91) begin
			// broken pair: lead followed by anything
			send_text(8'($urandom_range(8'hDF, 8'hC0)));
			send_text(8'($urandom_range(255, 0)));
		end else if (r < 94) begin
			it = make_item(ACT_LOAD, 8'($urandom_range(255, 0)));
			if ($urandom_range(3, 0) != 0)
				it.advance_width = ADV_W'($urandom_range(14, 0));
			send_item(it);
		end else if (r < 97) begin
			send_item(make_item(ACT_SET, 8'($urandom_range(255, 0))));
		end else begin
			send_item(make_item(ACT_NONE, 8'($urandom_range(255, 0))));
		end
	endtask

	initial begin
		text_item_t it;

		tracker                = new();
		arst_n                 = 1'b0;
		cfg_we                 = 1'b0;
		cfg_index              = '0;
		cfg_data               = '0;
		text_bus.valid         = 1'b0;
		text_bus.action        = ACT_TEXT;
		text_bus.byte_value    = '0;
		text_bus.advance_width = '0;
		text_bus.set_cursor_x  = '0;
		text_bus.set_cursor_y  = '0;
		cmd_bus.ready          = 1'b0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		set_idle(0);
		// the advance table has no reset value, so fill every entry first
		for (int i = 0; i < 256; i++) begin
			it = make_item(ACT_LOAD, 8'(i));
			it.advance_width = ADV_W'($urandom_range(12, 1));
			send_item(it);
		end
		run_directed();

		for (int p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				stop_sending();
				drain_block();
				program_phase(p);
			end
			set_idle(p % 4);
			text_sent = 0;
			while (text_sent < PHASE_ITEMS)
				send_random_unit();
		end

		stop_sending();
		drain_block();
		if (tracker.errors == 0 && tracker.due_cmds.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
